>>> rtl/memory_byte_colorizer_hsl_top_macros.svh
// Assertion macros for the memory byte colorizer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MEMORY_BYTE_COLORIZER_HSL_TOP_MACROS_SVH
`define MEMORY_BYTE_COLORIZER_HSL_TOP_MACROS_SVH

`define MBCHSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MBCHSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbchsl_pkg.sv
// Shared types, constants and the address region table of the colorizer.
// No dependencies.
package mbchsl_pkg;

  localparam int ADDR_BITS_DEF = 17;
  localparam int CFG_ADDR_W    = 3;
  localparam logic [0:0] REG_COLOR_MODE = 1'b0;

  localparam logic [31:0] BG_COLOR   = 32'hFF0A0A0F;
  localparam logic [7:0]  ALPHA      = 8'hFF;
  localparam logic [14:0] L_MAX      = 15'd29491;
  localparam logic [14:0] S_MIN      = 15'd9830;
  localparam logic [14:0] S_NORMAL   = 15'd26214;
  localparam logic [14:0] S_HEAT     = 15'd29491;
  localparam logic [16:0] DEG60      = 17'd15360;
  localparam logic [16:0] DEG120     = 17'd30720;
  localparam logic [15:0] ONE_Q15    = 16'h8000;

  typedef enum logic [1:0] {
    MODE_REGION  = 2'd0,
    MODE_PURPLE  = 2'd1,
    MODE_HEAT    = 2'd2,
    MODE_RAINBOW = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic               bg;
    logic [16:0]        h0;
    logic signed [34:0] hprod;
    logic [14:0]        l;
    logic [14:0]        s;
    logic [15:0]        boost;
  } hsl_t;

  function automatic logic [8:0] region_hue(input logic [31:0] addr);
    logic [8:0] hue;
    begin
      priority if (addr < 32'h100) begin
        hue = 9'd230;
      end else if (addr < 32'h200) begin
        hue = 9'd190;
      end else if (addr < 32'h2000) begin
        hue = 9'd280;
      end else if (addr < 32'h4000) begin
        hue = 9'd320;
      end else if (addr < 32'h8000) begin
        hue = 9'd45;
      end else begin
        hue = 9'd160;
      end
      return hue;
    end
  endfunction

endpackage

>>> rtl/mbchsl_hsl2rgb.sv
// Four-stage HSL to RGB back end: hue flash offset, chroma, sector and
// second component, then per-channel scaling and saturation. Uses mbchsl_pkg.
module mbchsl_hsl2rgb import mbchsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  hsl_t        in_hsl,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel
);

  function automatic logic [7:0] chan(input logic [15:0] q, input logic [14:0] m,
                                      input logic [15:0] boost);
    logic [16:0] sum;
    logic [24:0] prod;
    logic [18:0] val;
    begin
      sum  = 17'(q) + 17'(m);
      prod = 25'(sum) * 25'd255;
      val  = 19'(prod[24:7]) + 19'(boost);
      return (val[18:8] > 11'd255) ? 8'd255 : val[15:8];
    end
  endfunction

  logic p3_valid_r, p4_valid_r, p5_valid_r, p6_valid_r;
  logic en3, en4, en5, en6;

  assign en6 = !p6_valid_r || !out_stall;
  assign en5 = !p5_valid_r || en6;
  assign en4 = !p4_valid_r || en5;
  assign en3 = !p3_valid_r || en4;
  assign in_stall  = !en3;
  assign out_valid = p6_valid_r;

  // Stage 3: apply the flash hue shift and form the chroma product.
  logic signed [34:0] hadj;
  logic signed [18:0] hsum;
  logic [15:0] two_l, tdev, omt;
  logic [16:0] p3_h_nxt;
  logic [30:0] p3_cprod_nxt;

  always_comb begin
    hadj = (in_hsl.hprod < 0) ? ((in_hsl.hprod + 35'sd65535) >>> 16) : (in_hsl.hprod >>> 16);
    hsum = $signed({2'b00, in_hsl.h0}) + hadj[18:0];
    p3_h_nxt = hsum[16:0];
    two_l = {in_hsl.l, 1'b0};
    tdev  = (two_l >= ONE_Q15) ? (two_l - ONE_Q15) : (ONE_Q15 - two_l);
    omt   = ONE_Q15 - tdev;
    p3_cprod_nxt = 31'(omt) * 31'(in_hsl.s);
  end

  logic        p3_bg_r;
  logic [16:0] p3_h_r;
  logic [30:0] p3_cprod_r;
  logic [14:0] p3_l_r;
  logic [15:0] p3_boost_r;

  // Stage 4: chroma, hue sector, second component product and offset.
  logic [15:0] c4;
  sector_t     p4_sector_nxt;
  logic [16:0] base, hp;
  logic [13:0] fdev, wgt;
  logic [29:0] p4_xprod_nxt;
  logic [14:0] p4_m_nxt;

  always_comb begin
    c4 = p3_cprod_r[30:15];
    priority if (p3_h_r < DEG60) begin
      p4_sector_nxt = SEC_RY;
    end else if (p3_h_r < 17'd30720) begin
      p4_sector_nxt = SEC_YG;
    end else if (p3_h_r < 17'd46080) begin
      p4_sector_nxt = SEC_GC;
    end else if (p3_h_r < 17'd61440) begin
      p4_sector_nxt = SEC_CB;
    end else if (p3_h_r < 17'd76800) begin
      p4_sector_nxt = SEC_BM;
    end else begin
      p4_sector_nxt = SEC_MR;
    end
    priority if (p3_h_r < DEG120) begin
      base = 17'd0;
    end else if (p3_h_r < 17'd61440) begin
      base = DEG120;
    end else begin
      base = 17'd61440;
    end
    hp   = p3_h_r - base;
    fdev = (hp >= DEG60) ? 14'(hp - DEG60) : 14'(DEG60 - hp);
    wgt  = 14'(DEG60) - fdev;
    p4_xprod_nxt = 30'(c4) * 30'(wgt);
    p4_m_nxt = p3_l_r - c4[15:1];
  end

  logic        p4_bg_r;
  sector_t     p4_sector_r;
  logic [15:0] p4_c_r;
  logic [29:0] p4_xprod_r;
  logic [14:0] p4_m_r;
  logic [15:0] p4_boost_r;

  // Stage 5: divide the product by 15360 as a shift and a reciprocal of 15.
  logic [19:0] ydiv;
  logic [39:0] xq;
  logic [15:0] p5_x_nxt;

  always_comb begin
    ydiv = p4_xprod_r[29:10];
    xq   = 40'(ydiv) * 40'd559241;
    p5_x_nxt = xq[38:23];
  end

  logic        p5_bg_r;
  sector_t     p5_sector_r;
  logic [15:0] p5_c_r, p5_x_r;
  logic [14:0] p5_m_r;
  logic [15:0] p5_boost_r;

  // Stage 6: route chroma and second component, scale each channel.
  logic [15:0] qr, qg, qb;
  logic [31:0] p6_pixel_nxt;

  always_comb begin
    unique case (p5_sector_r)
      SEC_RY: begin qr = p5_c_r; qg = p5_x_r; qb = 16'd0;  end
      SEC_YG: begin qr = p5_x_r; qg = p5_c_r; qb = 16'd0;  end
      SEC_GC: begin qr = 16'd0;  qg = p5_c_r; qb = p5_x_r; end
      SEC_CB: begin qr = 16'd0;  qg = p5_x_r; qb = p5_c_r; end
      SEC_BM: begin qr = p5_x_r; qg = 16'd0;  qb = p5_c_r; end
      default: begin qr = p5_c_r; qg = 16'd0;  qb = p5_x_r; end
    endcase
    if (p5_bg_r) begin
      p6_pixel_nxt = BG_COLOR;
    end else begin
      p6_pixel_nxt = {ALPHA, chan(qr, p5_m_r, p5_boost_r), chan(qg, p5_m_r, p5_boost_r),
                      chan(qb, p5_m_r, p5_boost_r)};
    end
  end

  logic [31:0] p6_pixel_r;
  assign out_pixel = p6_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
      p6_valid_r <= 1'b0;
    end else begin
      if (en3) begin
        p3_valid_r <= in_valid;
      end
      if (en4) begin
        p4_valid_r <= p3_valid_r;
      end
      if (en5) begin
        p5_valid_r <= p4_valid_r;
      end
      if (en6) begin
        p6_valid_r <= p5_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      p3_bg_r    <= in_hsl.bg;
      p3_h_r     <= p3_h_nxt;
      p3_cprod_r <= p3_cprod_nxt;
      p3_l_r     <= in_hsl.l;
      p3_boost_r <= in_hsl.boost;
    end
    if (en4 && p3_valid_r) begin
      p4_bg_r     <= p3_bg_r;
      p4_sector_r <= p4_sector_nxt;
      p4_c_r      <= c4;
      p4_xprod_r  <= p4_xprod_nxt;
      p4_m_r      <= p4_m_nxt;
      p4_boost_r  <= p3_boost_r;
    end
    if (en5 && p4_valid_r) begin
      p5_bg_r     <= p4_bg_r;
      p5_sector_r <= p4_sector_r;
      p5_c_r      <= p4_c_r;
      p5_x_r      <= p5_x_nxt;
      p5_m_r      <= p4_m_r;
      p5_boost_r  <= p4_boost_r;
    end
    if (en6 && p5_valid_r) begin
      p6_pixel_r <= p6_pixel_nxt;
    end
  end

endmodule

>>> rtl/memory_byte_colorizer_hsl_top.sv
// Memory byte colorizer: turns each memory byte beat into one ARGB pixel.
// The block accepts one beat per clock and returns its pixel through its six
// register stages (hue, saturation and lightness, flash terms, hue shift and
// chroma, sector, division, channel scaling); a stall on the output fills
// bubbles first and then holds the input. color_mode sits at byte address 0 of
// the APB-style port; the user must write it only while no beat is in flight,
// which the block does not enforce. Uses mbchsl_pkg, mbchsl_hsl2rgb and macros.
module memory_byte_colorizer_hsl_top import mbchsl_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte_value,
  input  logic [ADDR_BITS-1:0]  in_byte_address,
  input  logic [15:0]           in_change_age,
  input  logic [15:0]           in_heat_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_pixel_argb
);

  `include "memory_byte_colorizer_hsl_top_macros.svh"

  mode_t color_mode_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLOR_MODE) ? {30'd0, color_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= MODE_REGION;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_MODE)) begin
      color_mode_r <= mode_t'(pwdata[1:0]);
    end
  end

  logic p1_valid_r, p2_valid_r;
  logic en1, en2, core_stall;

  assign en2 = !p2_valid_r || !core_stall;
  assign en1 = !p1_valid_r || en2;
  assign in_stall = !en1;

  // Stage 1: base hue, saturation, lightness and the flash term.
  logic [15:0] age_sat, heat_sat;
  logic [31:0] flash_prod;
  logic [23:0] heat_term;
  logic [15:0] lr;
  logic [32:0] lq_prod;
  logic [9:0]  ry;
  logic [19:0] rq_prod;
  logic [16:0] rain_hue;
  logic [15:0] p1_flash_nxt;
  logic [14:0] p1_l_nxt, p1_s_nxt;
  logic [16:0] p1_h_nxt;
  logic        p1_bg_nxt;

  always_comb begin
    age_sat  = (in_change_age > ONE_Q15) ? ONE_Q15 : in_change_age;
    heat_sat = (in_heat_level > ONE_Q15) ? ONE_Q15 : in_heat_level;
    flash_prod   = 32'(age_sat) * 32'(age_sat);
    p1_flash_nxt = flash_prod[30:15];
    p1_bg_nxt    = (in_byte_value == 8'd0) && (age_sat == 16'd0);

    lr       = 16'(in_byte_value) * 16'd211 + 16'd127;
    lq_prod  = 33'(lr) * 33'd65794;
    p1_l_nxt = 15'd4915 + 15'(15'(in_byte_value) * 15'd57) + 15'(lq_prod[31:24]);

    ry       = 10'(in_byte_value) * 10'd3 + 10'd8;
    rq_prod  = 20'(ry) * 20'd964;
    rain_hue = 17'(in_byte_value) * 17'd301 + 17'(rq_prod[19:14]);

    heat_term = 24'(heat_sat) * 24'd180 + 24'd64;

    p1_s_nxt = S_NORMAL;
    unique case (color_mode_r)
      MODE_REGION:  p1_h_nxt = {region_hue(32'(in_byte_address)), 8'd0};
      MODE_PURPLE:  p1_h_nxt = {9'd280, 8'd0};
      MODE_HEAT: begin
        p1_h_nxt = 17'd61440 - 17'(heat_term[22:7]);
        p1_s_nxt = S_HEAT;
      end
      MODE_RAINBOW: p1_h_nxt = rain_hue;
    endcase
  end

  logic        p1_bg_r;
  logic [15:0] p1_flash_r;
  logic [14:0] p1_l_r, p1_s_r;
  logic [16:0] p1_h_r;

  // Stage 2: flash brightening, desaturation, boost and hue shift product.
  logic [15:0] l_sum;
  logic [29:0] sdec_prod;
  logic [14:0] s_tmp;
  logic [31:0] boost_prod;
  logic signed [17:0] dh;
  hsl_t p2_nxt, p2_r;

  always_comb begin
    l_sum      = 16'(p1_l_r) + 16'(p1_flash_r[15:1]);
    sdec_prod  = 30'(p1_flash_r) * 30'd9830;
    s_tmp      = p1_s_r - sdec_prod[29:15];
    boost_prod = 32'(p1_flash_r) * 32'd38400;
    dh         = $signed({1'b0, DEG60}) - $signed({1'b0, p1_h_r});

    p2_nxt.bg    = p1_bg_r;
    p2_nxt.h0    = p1_h_r;
    p2_nxt.hprod = 35'(dh) * 35'($signed({1'b0, p1_flash_r}));
    p2_nxt.l     = (l_sum > 16'(L_MAX)) ? L_MAX : l_sum[14:0];
    p2_nxt.s     = (s_tmp < S_MIN) ? S_MIN : s_tmp;
    p2_nxt.boost = boost_prod[30:15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        p1_valid_r <= in_valid;
      end
      if (en2) begin
        p2_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p1_bg_r    <= p1_bg_nxt;
      p1_flash_r <= p1_flash_nxt;
      p1_l_r     <= p1_l_nxt;
      p1_s_r     <= p1_s_nxt;
      p1_h_r     <= p1_h_nxt;
    end
    if (en2 && p1_valid_r) begin
      p2_r <= p2_nxt;
    end
  end

  mbchsl_hsl2rgb u_hsl2rgb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p2_valid_r),
    .in_stall  (core_stall),
    .in_hsl    (p2_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel_argb)
  );

  `MBCHSL_ASSERT_NEXT(a_accept_fills_stage1, in_valid && !in_stall, p1_valid_r, "beat lost")
  `MBCHSL_ASSERT_SAME(a_stall_only_when_full, in_stall, p1_valid_r && p2_valid_r, "early stall")
  `MBCHSL_ASSERT_SAME(a_flash_in_range, p1_valid_r, p1_flash_r <= ONE_Q15, "flash above one")

endmodule

>>> test/argb_pixel_checker.sv
// Pixel checker for the memory byte colorizer: follows the color_mode register on the
// APB-style port, predicts the ARGB pixel of every accepted byte beat and compares results.
// Depends on mbchsl_pkg for the mode enum, the background color and the address width.
module argb_pixel_checker import mbchsl_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte_value,
  input  logic [ADDR_BITS-1:0]  in_byte_address,
  input  logic [15:0]           in_change_age,
  input  logic [15:0]           in_heat_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [31:0]           out_pixel_argb,
  output int                    failures,
  output int                    pending,
  output int                    pixels_checked
);

  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = CFG_ADDR_W'(REG_COLOR_MODE) << 2;
  localparam longint UNIT     = 32768;
  localparam longint HUE_60   = 15360;
  localparam longint HUE_120  = 30720;
  localparam longint HUE_360  = 92160;
  localparam longint LIGHT_CAP = 29491;
  localparam longint SAT_FLOOR = 9830;
  localparam longint SAT_BASE  = 26214;
  localparam longint SAT_HEAT  = 29491;

  mode_t       mode_shadow = MODE_REGION;
  logic [31:0] expected_pixels[$];
  logic [31:0] predicted;
  logic [31:0] oldest;
  int          fail_cnt = 0;
  int          match_cnt = 0;

  function automatic longint region_degrees(input logic [ADDR_BITS-1:0] addr);
    logic [31:0] a;
    a = 32'(addr);
    if (a < 32'h100) return 230;
    if (a < 32'h200) return 190;
    if (a < 32'h2000) return 280;
    if (a < 32'h4000) return 320;
    if (a < 32'h8000) return 45;
    return 160;
  endfunction

  function automatic logic [7:0] channel_level(input longint q, input longint m,
                                               input longint boost);
    longint lvl;
    lvl = ((q + m) * 255) / 128 + boost;
    if (lvl < 0) lvl = 0;
    lvl = lvl / 256;
    if (lvl > 255) lvl = 255;
    return lvl[7:0];
  endfunction

  function automatic logic [31:0] predict_pixel(input mode_t mode, input logic [7:0] val,
                                                input logic [ADDR_BITS-1:0] addr,
                                                input logic [15:0] age_raw,
                                                input logic [15:0] heat_raw);
    longint v, age, heat, h, s, l, boost, flash, t, c, x, m, f, qr, qg, qb;
    v = val;
    age = age_raw;
    heat = heat_raw;
    if (age > UNIT) age = UNIT;
    if (heat > UNIT) heat = UNIT;
    if (v == 0 && age == 0) return BG_COLOR;
    s = SAT_BASE;
    boost = 0;
    l = 4915 + (v * 14746 + 127) / 255;
    case (mode)
      MODE_REGION: h = region_degrees(addr) * 256;
      MODE_PURPLE: h = 280 * 256;
      MODE_HEAT: begin
        h = 61440 - ((heat * 180 + 64) >>> 7);
        s = SAT_HEAT;
      end
      default: h = (v * 76800 + 127) / 255;
    endcase
    if (age > 0) begin
      flash = (age * age) >>> 15;
      l = l + (flash >>> 1);
      if (l > LIGHT_CAP) l = LIGHT_CAP;
      s = s - ((flash * 9830) >>> 15);
      if (s < SAT_FLOOR) s = SAT_FLOOR;
      boost = (flash * 150 * 256) >>> 15;
      h = h + ((HUE_60 - h) * flash) / 65536;
    end
    while (h < 0) h = h + HUE_360;
    while (h >= HUE_360) h = h - HUE_360;
    t = 2 * l - UNIT;
    if (t < 0) t = -t;
    c = ((UNIT - t) * s) / UNIT;
    f = (h % HUE_120) - HUE_60;
    if (f < 0) f = -f;
    x = (c * (HUE_60 - f)) / HUE_60;
    m = l - c / 2;
    case (h / HUE_60)
      0: begin qr = c; qg = x; qb = 0; end
      1: begin qr = x; qg = c; qb = 0; end
      2: begin qr = 0; qg = c; qb = x; end
      3: begin qr = 0; qg = x; qb = c; end
      4: begin qr = x; qg = 0; qb = c; end
      default: begin qr = c; qg = 0; qb = x; end
    endcase
    return {ALPHA, channel_level(qr, m, boost), channel_level(qg, m, boost),
            channel_level(qb, m, boost)};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_shadow = MODE_REGION;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == MODE_ADDR) mode_shadow = mode_t'(pwdata[1:0]);
        end else if (paddr == MODE_ADDR && prdata !== {30'b0, mode_shadow}) begin
          $display("%0t: color_mode readback mismatch, expected %08h, got %08h",
                   $time, {30'b0, mode_shadow}, prdata);
          fail_cnt++;
        end
      end
      if (in_valid && !in_stall) begin
        predicted = predict_pixel(mode_shadow, in_byte_value, in_byte_address,
                                  in_change_age, in_heat_level);
        expected_pixels = {expected_pixels, predicted};
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel beat, expected none, got %08h",
                   $time, out_pixel_argb);
          fail_cnt++;
        end else begin
          oldest = expected_pixels.pop_front();
          if (out_pixel_argb !== oldest) begin
            $display("%0t: pixel_argb mismatch, expected %08h, got %08h",
                     $time, oldest, out_pixel_argb);
            fail_cnt++;
          end
          match_cnt++;
        end
      end
    end
    failures <= fail_cnt;
    pending <= expected_pixels.size();
    pixels_checked <= match_cnt;
  end

endmodule

>>> test/memory_byte_colorizer_hsl_top_test.sv
// Testbench top for the memory byte colorizer: drives directed and random byte beats,
// switches color_mode between phases and gives the verdict.
// Depends on mbchsl_pkg, memory_byte_colorizer_hsl_top and argb_pixel_checker.
module memory_byte_colorizer_hsl_top_test;
  import mbchsl_pkg::*;

  localparam int LATENCY = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_BEATS = 210;
  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR  = CFG_ADDR_W'(REG_COLOR_MODE) << 2;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4);

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_W-1:0]    paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_stall;
  logic [7:0]               in_byte_value;
  logic [ADDR_BITS_DEF-1:0] in_byte_address;
  logic [15:0]              in_change_age;
  logic [15:0]              in_heat_level;
  logic                     out_valid;
  logic                     out_stall;
  logic [31:0]              out_pixel_argb;

  int failures;
  int pending;
  int pixels_checked;
  int src_pct = 6;
  int sink_pct = 48;
  bit long_hold = 1'b0;
  int beats_sent = 0;
  int mode_writes = 0;

  memory_byte_colorizer_hsl_top dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte_value(in_byte_value),
    .in_byte_address(in_byte_address), .in_change_age(in_change_age),
    .in_heat_level(in_heat_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_argb(out_pixel_argb)
  );

  argb_pixel_checker pixel_check (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte_value(in_byte_value),
    .in_byte_address(in_byte_address), .in_change_age(in_change_age),
    .in_heat_level(in_heat_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_argb(out_pixel_argb),
    .failures(failures), .pending(pending), .pixels_checked(pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      out_stall <= ($urandom_range(99) < sink_pct);
    end
  end

  task automatic send_beat(input logic [7:0] v, input logic [ADDR_BITS_DEF-1:0] a,
                           input logic [15:0] age, input logic [15:0] heat);
    while ($urandom_range(99) < src_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= v;
    in_byte_address <= a;
    in_change_age <= age;
    in_heat_level <= heat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input mode_t mode);
    apb_access(1'b1, MODE_ADDR, {30'($urandom), mode});
    apb_access(1'b0, MODE_ADDR, 32'h0);
    mode_writes++;
  endtask

  function automatic logic [15:0] q15_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'h0000;
      4: return 16'h8000;
      5: return 16'($urandom_range(16'h8001, 16'hFFFF));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic random_beat();
    logic [7:0] v;
    logic [ADDR_BITS_DEF-1:0] a;
    case ($urandom_range(9))
      0, 1: v = 8'h00;
      2: v = 8'hFF;
      default: v = 8'($urandom);
    endcase
    a = ADDR_BITS_DEF'($urandom) >> $urandom_range(16);
    send_beat(v, a, q15_sample(), q15_sample());
  endtask

  initial begin
    mode_t phase_modes[6];
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_byte_value <= '0;
    in_byte_address <= '0;
    in_change_age <= '0;
    in_heat_level <= '0;
    phase_modes = '{MODE_HEAT, MODE_PURPLE, MODE_RAINBOW, MODE_REGION, MODE_RAINBOW,
                    MODE_HEAT};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset mode is the address region table: walk every region boundary.
    send_beat(8'h00, 17'h00000, 16'h0000, 16'h0000);
    send_beat(8'h00, 17'h1FFFF, 16'h0000, 16'hFFFF);
    send_beat(8'h00, 17'h00010, 16'h0001, 16'h0000);
    send_beat(8'h01, 17'h00000, 16'h0000, 16'h0000);
    send_beat(8'hFF, 17'h000FF, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h00100, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h001FF, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h00200, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h01FFF, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h02000, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h03FFF, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h04000, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h07FFF, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h08000, 16'h0000, 16'h0000);
    send_beat(8'hFF, 17'h1FFFF, 16'h0000, 16'h0000);
    send_beat(8'h80, 17'h00300, 16'h8000, 16'h0000);
    send_beat(8'h40, 17'h05000, 16'h8001, 16'h0000);
    send_beat(8'h20, 17'h10000, 16'hFFFF, 16'hFFFF);
    send_beat(8'hC0, 17'h00050, 16'h4000, 16'h0000);
    send_beat(8'hFF, 17'h00180, 16'h8000, 16'h8000);
    drain();
    set_mode(MODE_HEAT);
    send_beat(8'h55, 17'h00000, 16'h0000, 16'h0000);
    send_beat(8'h55, 17'h00000, 16'h0000, 16'h8000);
    send_beat(8'hAA, 17'h00000, 16'h2000, 16'hFFFF);
    drain();
    set_mode(MODE_RAINBOW);
    send_beat(8'h00, 17'h00000, 16'h0001, 16'h0000);
    send_beat(8'hFF, 17'h00000, 16'h0000, 16'h0000);
    drain();

    for (int p = 0; p < 6; p++) begin
      src_pct = (p < 2) ? 6 : (p < 4) ? 48 : 0;
      sink_pct = (p < 2) ? 48 : (p < 4) ? 6 : 0;
      // A write to an address with no register must leave color_mode alone.
      if (p == 3) apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFE);
      set_mode(phase_modes[p]);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p == 4 && n == 20) long_hold = 1'b1;
        random_beat();
      end
      drain();
    end

    $display("Sent %0d byte beats under %0d color_mode writes and checked %0d pixels,",
             beats_sent, mode_writes, pixels_checked);
    $display("with both idling patterns, a long output hold and full drains between phases.");
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
